/* src/oets_pkg.sv */
// oets_pkg: shared widths, sizes and the queue entry type of the odd-even
// transposition sorter
// no dependencies

package oets_pkg;

    localparam int MAX_ELEMS   = 64;
    localparam int VALUE_W     = 32;
    localparam int QUEUE_DEPTH = 2;

    // one entry between the front and the back
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               keep;     // value fits in the store
        logic               last;     // closes the set
        logic               ovf;      // some value of this set was dropped
    } entry_t;

endpackage

/* src/oets_front.sv */
// oets_front: accepts input words, counts the set and marks dropped values
// depends on oets_pkg

module oets_front #(
    parameter int MAX_ELEMS = oets_pkg::MAX_ELEMS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [oets_pkg::VALUE_W-1:0]   s_tdata,
    input  logic                           s_tlast,
    input  logic                           q_full,
    output logic                           q_push,
    output oets_pkg::entry_t               q_entry
);

    localparam int CW = $clog2(MAX_ELEMS + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          keep;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign keep     = count_reg < CW'(MAX_ELEMS);

    always_comb begin
        q_entry.value = s_tdata;
        q_entry.keep  = keep;
        q_entry.last  = s_tlast;
        q_entry.ovf   = ovf_reg || !keep;
    end

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (q_push) begin
            if (s_tlast) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end else begin
                if (keep) begin
                    count_next = count_reg + CW'(1);
                end
                ovf_next = ovf_reg || !keep;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

/* src/oets_fifo.sv */
// oets_fifo: short queue of entries between the front and the back
// depends on oets_pkg

module oets_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  oets_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output oets_pkg::entry_t  pop_entry,
    output logic              empty
);

    localparam int DEPTH = oets_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    oets_pkg::entry_t mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full      = fill_reg == CW'(DEPTH);
    assign empty     = fill_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* src/oets_back.sv */
// oets_back: row of element cells that loads a set, sorts it by odd-even
// transposition phases and shifts it out; depends on oets_pkg

module oets_back #(
    parameter int MAX_ELEMS = oets_pkg::MAX_ELEMS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  oets_pkg::entry_t               q_entry,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [oets_pkg::VALUE_W-1:0]   m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    localparam int CW = $clog2(MAX_ELEMS + 1);
    localparam int VW = oets_pkg::VALUE_W;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] phase_reg, phase_next;
    logic          ovf_reg, ovf_next;

    logic [VW-1:0] elem_reg  [MAX_ELEMS];
    logic [VW-1:0] elem_next [MAX_ELEMS];
    logic [MAX_ELEMS-2:0] swap;
    logic          emit_go;

    assign q_pop    = (state_reg == ST_LOAD) && !q_empty;
    assign m_tvalid = state_reg == ST_EMIT;
    assign m_tdata  = elem_reg[0];
    assign m_tlast  = count_reg == CW'(1);
    assign m_tuser  = ovf_reg;
    assign emit_go  = m_tvalid && m_tready;

    // comparators between neighbor cells; a pair works only in its phase
    // parity and only inside the loaded set
    for (genvar k = 0; k < MAX_ELEMS - 1; k++) begin : g_pair
        always_comb begin
            swap[k] = (state_reg == ST_SORT)
                   && (phase_reg[0] == 1'(k % 2))
                   && (CW'(k + 1) < count_reg)
                   && ($signed(elem_reg[k]) > $signed(elem_reg[k + 1]));
        end
    end

    for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
        always_comb begin
            elem_next[i] = elem_reg[i];
            unique case (state_reg)
                ST_LOAD: begin
                    if (q_pop && q_entry.keep && count_reg == CW'(i)) begin
                        elem_next[i] = q_entry.value;
                    end
                end
                ST_SORT: begin
                    if (i > 0) begin
                        if (swap[(i > 0) ? i - 1 : 0]) begin
                            elem_next[i] = elem_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                    if (i < MAX_ELEMS - 1) begin
                        if (swap[(i < MAX_ELEMS - 1) ? i : 0]) begin
                            elem_next[i] = elem_reg[(i < MAX_ELEMS - 1) ? i + 1 : i];
                        end
                    end
                end
                ST_EMIT: begin
                    // shift toward cell 0 as each word leaves
                    if (emit_go && i < MAX_ELEMS - 1) begin
                        elem_next[i] = elem_reg[(i < MAX_ELEMS - 1) ? i + 1 : i];
                    end
                end
                default: begin
                    elem_next[i] = elem_reg[i];
                end
            endcase
        end

        always_ff @(posedge aclk) begin
            elem_reg[i] <= elem_next[i];
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (q_pop) begin
                    if (q_entry.keep) begin
                        count_next = count_reg + CW'(1);
                    end
                    if (q_entry.last) begin
                        ovf_next   = q_entry.ovf;
                        phase_next = '0;
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                // as many phases as loaded values
                phase_next = phase_reg + CW'(1);
                if (phase_reg == count_reg - CW'(1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1)) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            phase_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

/* src/odd_even_transposition_sorter.sv */
// odd_even_transposition_sorter: top level, front end, queue and sorting back end
// depends on oets_pkg, oets_front, oets_fifo, oets_back
//
//   channel  dir  handshake            tdata                tlast        tuser
//   s_       in   s_tvalid/s_tready    value[31:0]          is_last      -
//   m_       out  m_tvalid/m_tready    sorted_value[31:0]   end_of_run   overflowed
//
// each input word is taken while the queue has room; the back end loads one word
// per cycle from the queue into its row of cells while the queue is not empty
// after the last word of a set the cell row runs n compare-exchange phases, one
// per cycle, then shifts out n words at one per cycle while m_tready is high;
// while the back is busy the front takes up to QUEUE_DEPTH (2) words of the
// next set into the queue and then holds s_tready low
// reset (aresetn low, synchronous) empties the queue and the set counters
// a stall on m_ holds the row; the queue fills and then s_tready drops

module odd_even_transposition_sorter #(
    parameter int MAX_ELEMS = oets_pkg::MAX_ELEMS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [oets_pkg::VALUE_W-1:0]   s_tdata,   // value
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [oets_pkg::VALUE_W-1:0]   m_tdata,   // sorted_value
    output logic                           m_tlast,
    output logic                           m_tuser    // overflowed
);

    oets_pkg::entry_t push_entry, pop_entry;
    logic             push, pop, full, empty;

    oets_front #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    oets_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    oets_back #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (empty),
        .q_entry  (pop_entry),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* test/odd_even_transposition_sorter_tb.sv */
`timescale 1ns / 1ps
// odd_even_transposition_sorter_tb: self-checking bench for the odd-even transposition sorter
// depends on oets_pkg and odd_even_transposition_sorter; predicts each sorted set in a class

typedef struct packed {
    logic [oets_pkg::VALUE_W-1:0] value;
    logic                         last;
    logic                         ovf;
} sorted_word_t;

class sort_board;
    logic [oets_pkg::VALUE_W-1:0] held_values[$];
    logic                         dropped;
    sorted_word_t                 awaited_words[$];
    int                           errors;

    function new();
        dropped = 1'b0;
        errors  = 0;
    endfunction

    // collect one input word; on the closing word sort the set and queue the results
    function void take_value(logic [oets_pkg::VALUE_W-1:0] value, logic last);
        logic signed [oets_pkg::VALUE_W-1:0] row [oets_pkg::MAX_ELEMS];
        logic signed [oets_pkg::VALUE_W-1:0] tmp;
        sorted_word_t                        word;
        int                                  n;
        if (held_values.size() < oets_pkg::MAX_ELEMS)
            held_values.push_back(value);
        else
            dropped = 1'b1;
        if (!last)
            return;
        n = held_values.size();
        for (int i = 0; i < n; i++)
            row[i] = held_values[i];
        // even phases compare (0,1),(2,3)..; odd phases (1,2),(3,4)..
        for (int p = 0; p < n; p++) begin
            for (int k = p % 2; k + 1 < n; k += 2) begin
                if (row[k] > row[k+1]) begin
                    tmp      = row[k];
                    row[k]   = row[k+1];
                    row[k+1] = tmp;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            word.value = row[k];
            word.last  = (k == n - 1);
            word.ovf   = dropped;
            awaited_words.push_back(word);
        end
        held_values.delete();
        dropped = 1'b0;
    endfunction

    function void check_sorted_word(logic [oets_pkg::VALUE_W-1:0] value, logic last,
                                    logic ovf);
        sorted_word_t want;
        if (awaited_words.size() == 0) begin
            $display("%0t: unexpected word value=%h last=%b ovf=%b", $time, value, last, ovf);
            errors++;
            return;
        end
        want = awaited_words.pop_front();
        if (want.value !== value || want.last !== last || want.ovf !== ovf) begin
            $display("%0t: mismatch expected value=%h last=%b ovf=%b, got value=%h last=%b ovf=%b",
                     $time, want.value, want.last, want.ovf, value, last, ovf);
            errors++;
        end
    endfunction

    function int pending_count();
        return awaited_words.size();
    endfunction
endclass

module odd_even_transposition_sorter_tb;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 300;
    localparam int PHASE_ITEMS    = 55;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [oets_pkg::VALUE_W-1:0] s_tdata;    // value
    logic                         s_tlast;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [oets_pkg::VALUE_W-1:0] m_tdata;    // sorted_value
    logic                         m_tlast;
    logic                         m_tuser;    // overflowed

    sort_board board = new();
    int        tx_idle_pct;
    int        rx_idle_pct;
    bit        hold_request;
    int        cycle_count;

    odd_even_transposition_sorter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_sorted_word(m_tdata, m_tlast, m_tuser);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_word(logic [oets_pkg::VALUE_W-1:0] value, logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.take_value(value, last);
        @(negedge aclk);
    endtask

    function automatic logic [oets_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 15) - 8;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(int n);
        for (int i = 0; i < n; i++)
            send_word(random_value(), i == n - 1);
    endtask

    // mostly short sets, now and then a mid-sized one
    task automatic send_small_sets(int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
            send_set(n);
            sent += n;
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        hold_request = 1'b0;
        cycle_count  = 0;
        tx_idle_pct  = 16;
        rx_idle_pct  = 53;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // extremes and sign boundary
        send_word(32'h7fff_ffff, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hffff_ffff, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        // one-word sets
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h7fff_ffff, 1'b1);
        // equal values stay put
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b1);
        // descending input
        send_word(32'd3, 1'b0);
        send_word(32'd2, 1'b0);
        send_word(32'd1, 1'b0);
        send_word(32'd0, 1'b1);
        // two words, one swap
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hffff_ffff, 1'b1);

        // store filled exactly
        send_set(oets_pkg::MAX_ELEMS);
        send_small_sets(PHASE_ITEMS);

        tx_idle_pct = 53;
        rx_idle_pct = 16;
        // overflow, the closing word itself is dropped
        send_set(oets_pkg::MAX_ELEMS + 2);
        send_small_sets(PHASE_ITEMS);

        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        send_small_sets(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        while (board.pending_count() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending_count() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
